>>> rtl/tsa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the task slot allocator.
// No dependencies; used by tsa_cell and task_slot_allocator.
package tsa_pkg;

   localparam int CELL_W    = 64;   // slots held by one cell
   localparam int LOC_W     = 6;    // index bits inside a cell
   localparam int IDX_MAX_W = 16;   // widest slot index the pool supports
   localparam int CID_W     = IDX_MAX_W - LOC_W;
   localparam int GEN_W     = 32;
   localparam int ADDR_W    = 48;
   localparam int BYTES_W   = 21;
   localparam int REL_W     = 10;
   localparam int OUT_CNT_W = 11;
   localparam int STATUS_W  = 2;
   localparam int HANDLE_W  = 64;

   localparam logic [GEN_W-1:0] GEN_RESET   = 32'd1;
   localparam logic [BYTES_W-1:0] BYTES_RESET = 21'd8192;

   // commands
   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // response status
   localparam logic [STATUS_W-1:0] STAT_ALLOCATED = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RELEASED  = 2'd2;

   // csr indexes
   localparam logic CSR_STACK_BASE  = 1'b0;
   localparam logic CSR_STACK_BYTES = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIND,
      ST_DONE
   } state_type;

   // set or clear one bit of the slot map
   typedef struct packed {
      logic                 valid;
      logic                 set;
      logic [IDX_MAX_W-1:0] idx;
   } cell_upd_type;

   // lowest free slot seen from a cell toward the top of the pool
   typedef struct packed {
      logic                 found;
      logic [IDX_MAX_W-1:0] idx;
   } link_type;

   // bits of a cell that map onto real slots
   function automatic logic [CELL_W-1:0] live_mask(int cell_id, int slots);
      logic [CELL_W-1:0] m;
      m = '0;
      for (int j = 0; j < CELL_W; j++) begin
         m[j] = ((cell_id * CELL_W + j) < slots);
      end
      return m;
   endfunction

endpackage

>>> rtl/tsa_cell.sv
`timescale 1ns / 1ps
// One cell of the slot map chain: 64 busy bits plus a registered
// lowest-free link passed toward cell 0. Depends on tsa_pkg.
module tsa_cell #(
   parameter int CELL_ID = 0,
   parameter int SLOTS   = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tsa_pkg::cell_upd_type upd,
   input  tsa_pkg::link_type     link_in,
   output tsa_pkg::link_type     link_out
);
   import tsa_pkg::*;

   localparam logic [CELL_W-1:0] LIVE = live_mask(CELL_ID, SLOTS);
   localparam logic [IDX_MAX_W-1:0] BASE = IDX_MAX_W'(CELL_ID * CELL_W);

   logic [CELL_W-1:0] busy_ff, busy_in;
   link_type          link_ff, link_in_nxt;
   logic              hit;
   logic [CELL_W-1:0] free;
   logic              any_free;
   logic [LOC_W-1:0]  loc;

   assign hit = upd.valid && (upd.idx[IDX_MAX_W-1:LOC_W] == CID_W'(CELL_ID));

   always_comb begin
      busy_in = busy_ff;
      if (hit) begin
         busy_in[upd.idx[LOC_W-1:0]] = upd.set;
      end
   end

   // padding bits past the pool never count as free
   assign free     = ~busy_ff & LIVE;
   assign any_free = |free;

   always_comb begin
      loc = '0;
      for (int j = CELL_W - 1; j >= 0; j--) begin
         if (free[j]) loc = LOC_W'(j);
      end
   end

   always_comb begin
      if (any_free) begin
         link_in_nxt.found = 1'b1;
         link_in_nxt.idx   = BASE + IDX_MAX_W'(loc);
      end else begin
         link_in_nxt = link_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         link_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         link_ff <= link_in_nxt;
      end
   end

   assign link_out = link_ff;

endmodule

>>> rtl/task_slot_allocator.sv
`timescale 1ns / 1ps
// Task slot allocator: hands out the lowest free slot with a generation-tagged handle.
// A req beat passes through accept, search/map update and result before its rsp beat;
// a new req beat is taken only once the previous result has been loaded. After a beat that
// changes the slot map, the next beat waits for the lowest-free link to ripple down the
// cell chain of NCELLS cells (SLOTS/64, rounded up); an unchanged map adds no wait.
// Reset (sync, active high): every slot free, generation 1, use count 0,
// stack base 0, stack size 8192; req_ready stays low while the chain settles.
module task_slot_allocator #(
   parameter int SLOTS = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   // command channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_cmd,
   input  logic [tsa_pkg::REL_W-1:0]          req_release_slot,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tsa_pkg::STATUS_W-1:0]       rsp_status,
   output logic [tsa_pkg::HANDLE_W-1:0]       rsp_handle,
   output logic [tsa_pkg::REL_W-1:0]          rsp_slot_index,
   output logic [tsa_pkg::ADDR_W-1:0]         rsp_stack_address,
   output logic [tsa_pkg::OUT_CNT_W-1:0]      rsp_slots_in_use,
   // configuration writes
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [tsa_pkg::ADDR_W-1:0]         csr_wdata
);
   import tsa_pkg::*;

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int NCELLS = (SLOTS + CELL_W - 1) / CELL_W;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int SET_W  = $clog2(NCELLS + 1);
   localparam int PROD_W = BYTES_W + IDX_W;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [ADDR_W-1:0]  base_ff;
   logic [BYTES_W-1:0] bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         bytes_ff <= BYTES_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STACK_BASE:  base_ff  <= csr_wdata;
            CSR_STACK_BYTES: bytes_ff <= csr_wdata[BYTES_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Cell chain. Cell i takes the link of cell i+1; cell 0's link is
   // the lowest free slot of the whole pool once the chain has settled.
   // ---------------------------------------------------------------
   cell_upd_type upd;
   link_type     links [NCELLS+1];

   assign links[NCELLS] = '0;

   for (genvar c = 0; c < NCELLS; c++) begin : g_cell
      tsa_cell #(
         .CELL_ID (c),
         .SLOTS   (SLOTS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .upd      (upd),
         .link_in  (links[c+1]),
         .link_out (links[c])
      );
   end

   link_type head;
   assign head = links[0];

   // ---------------------------------------------------------------
   // Control
   // ---------------------------------------------------------------
   state_type state_ff, state_in;
   logic [SET_W-1:0] settle_ff, settle_in;   // cycles until cell 0 is current
   logic             rsp_valid_ff, rsp_valid_in;
   logic [GEN_W-1:0] gen_ff, gen_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // beat held across the search
   logic             cmd_ff;
   logic [REL_W-1:0] rel_ff;
   logic             ok_ff, ok_in;       // slot found (alloc) or index in range (release)
   logic [IDX_W-1:0] idx_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;

   logic req_fire, load_rsp, rel_in_range;

   assign req_fire     = req_valid && req_ready;
   assign rel_in_range = (32'(rel_ff) < 32'(SLOTS));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_FIND;
         ST_FIND: state_in = ST_DONE;
         ST_DONE: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      upd       = '0;
      ok_in     = ok_ff;
      unique case (state_ff)
         ST_IDLE: req_ready = (settle_ff == '0);
         ST_FIND: begin
            if (cmd_ff == CMD_ALLOC) begin
               ok_in     = head.found;
               upd.valid = head.found;
               upd.set   = 1'b1;
               upd.idx   = head.idx;
            end else begin
               ok_in     = rel_in_range;
               upd.valid = rel_in_range;
               upd.set   = 1'b0;
               upd.idx   = IDX_MAX_W'(rel_ff);
            end
         end
         ST_DONE: load_rsp = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // cell 0 is stale after any map write until the link has rippled down the chain
   always_comb begin
      if (upd.valid) begin
         settle_in = SET_W'(NCELLS);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else begin
         settle_in = settle_ff;
      end
   end

   // stack offset of the found slot, registered before the add
   assign prod_in = PROD_W'(bytes_ff) * PROD_W'(IDX_W'(head.idx));

   // generation and use count move when the result is written
   always_comb begin
      gen_in = gen_ff;
      cnt_in = cnt_ff;
      if (load_rsp && ok_ff) begin
         if (cmd_ff == CMD_ALLOC) begin
            cnt_in = cnt_ff + 1'b1;
            gen_in = gen_ff + 1'b1;
            if (gen_in == '0) gen_in = GEN_RESET;   // zero is never a live generation
         end else if (cnt_ff != '0) begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         settle_ff    <= SET_W'(NCELLS);
         rsp_valid_ff <= 1'b0;
         gen_ff       <= GEN_RESET;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         settle_ff    <= settle_in;
         rsp_valid_ff <= rsp_valid_in;
         gen_ff       <= gen_in;
         cnt_ff       <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff <= req_cmd;
         rel_ff <= req_release_slot;
      end
      if (state_ff == ST_FIND) begin
         ok_ff   <= ok_in;
         idx_ff  <= IDX_W'(head.idx);
         prod_ff <= prod_in;
      end
   end

   // result beat
   logic [STATUS_W-1:0]  status_ff;
   logic [HANDLE_W-1:0]  handle_ff;
   logic [REL_W-1:0]     slot_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [OUT_CNT_W-1:0] in_use_ff;

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         in_use_ff <= OUT_CNT_W'(cnt_in);
         if (cmd_ff == CMD_RELEASE) begin
            status_ff <= STAT_RELEASED;
            handle_ff <= '0;
            slot_ff   <= rel_ff;
            addr_ff   <= '0;
         end else if (ok_ff) begin
            status_ff <= STAT_ALLOCATED;
            handle_ff <= {gen_ff, 32'(idx_ff)};
            slot_ff   <= REL_W'(idx_ff);
            addr_ff   <= base_ff + ADDR_W'(prod_ff);
         end else begin
            status_ff <= STAT_FULL;
            handle_ff <= '0;
            slot_ff   <= '0;
            addr_ff   <= '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_handle        = handle_ff;
   assign rsp_slot_index    = slot_ff;
   assign rsp_stack_address = addr_ff;
   assign rsp_slots_in_use  = in_use_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_gen_nonzero: assert property (@(posedge clock) disable iff (reset)
      gen_ff != '0)
      else $error("generation counter reached zero");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= 32'(SLOTS))
      else $error("use count above pool size");

   a_upd_in_find: assert property (@(posedge clock) disable iff (reset)
      upd.valid |-> (state_ff == ST_FIND))
      else $error("slot map written outside the search cycle");

   a_map_write_settles: assert property (@(posedge clock) disable iff (reset)
      upd.valid |=> (settle_ff == SET_W'(NCELLS)) && !req_ready)
      else $error("map write did not restart the settle count");

   a_alloc_gen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_ALLOCATED) |-> (rsp_handle[HANDLE_W-1:32] != '0))
      else $error("allocated handle carries generation zero");

endmodule
